FILE: sv/crcfb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package crcfb_pkg;

  // Frame constants.
  localparam logic [7:0]  MAGIC_A     = 8'h53;
  localparam logic [7:0]  MAGIC_B     = 8'h45;
  localparam logic [7:0]  VERSION_RST = 8'h02;
  localparam logic [15:0] CRC_INIT    = 16'hFFFF;
  localparam logic [15:0] CRC_POLY    = 16'h1021;

  // Status codes on the result channel.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_LEN = 2'd1;
  localparam logic [1:0] ST_OUTSIDE = 2'd2;

  // One accepted input item.
  typedef struct packed {
    logic       start_req;
    logic [7:0] message_id;
    logic [7:0] payload_length;
    logic [7:0] data_byte;
  } item_t;

  // One result item.
  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_end;
    logic [1:0] status;
  } result_t;

  // CRC-16/CCITT-FALSE update by one byte, MSB first.
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: sv/crcfb_in_reg.sv
`timescale 1ns / 1ps
`default_nettype none

module crcfb_in_reg (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire crcfb_pkg::item_t in_item,
  input  wire logic           item_done,
  output crcfb_pkg::item_t    item,
  output logic                item_valid
);
  import crcfb_pkg::*;

  logic load;

  // The register takes a new item when empty or when its item finishes now.
  assign in_stall = item_valid && !item_done;
  assign load     = in_valid && !in_stall;

  // Valid flag of the held item.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (load) begin
      item_valid <= 1'b1;
    end else if (item_done) begin
      item_valid <= 1'b0;
    end
  end

  // Payload of the held item.
  always_ff @(posedge clk) begin
    if (load) begin
      item <= in_item;
    end
  end

endmodule

`default_nettype wire

FILE: sv/crcfb_seq.sv
`timescale 1ns / 1ps
`default_nettype none

module crcfb_seq #(
  parameter int MAX_PAYLOAD = 64
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire crcfb_pkg::item_t item,
  input  wire logic             item_valid,
  input  wire logic             out_ready,
  input  wire logic [7:0]       version,
  output crcfb_pkg::result_t    res,
  output logic                  res_valid,
  output logic                  item_done
);
  import crcfb_pkg::*;

  localparam int         REM_W   = $clog2(MAX_PAYLOAD + 1);
  localparam logic [7:0] MAX_LEN = 8'(MAX_PAYLOAD);

  typedef enum logic [3:0] {
    P_FIRST,
    P_MAGA,
    P_MAGB,
    P_VER,
    P_ID,
    P_LEN,
    P_DATA,
    P_CRCL,
    P_CRCH,
    P_BADLEN,
    P_OUTSIDE
  } phase_t;

  phase_t            phase, phase_next, cur;
  logic              in_frame, in_frame_next;
  logic [REM_W-1:0]  rem, rem_next, rem_dec;
  logic [15:0]       crc, crc_next;
  logic              done_c, step;

  // One result is produced whenever an item is held and the output can take it.
  assign step      = item_valid && out_ready;
  assign res_valid = step;
  assign item_done = step && done_c;

  // The first result of an item is chosen from the item and the frame state.
  always_comb begin
    if (phase != P_FIRST) begin
      cur = phase;
    end else if (item.start_req) begin
      if (item.payload_length == 8'd0 || item.payload_length > MAX_LEN) begin
        cur = P_BADLEN;
      end else begin
        cur = P_MAGA;
      end
    end else if (in_frame) begin
      cur = P_DATA;
    end else begin
      cur = P_OUTSIDE;
    end
  end

  assign rem_dec = (rem != '0) ? rem - 1'b1 : rem;

  // Result byte and state update for the current phase.
  always_comb begin
    res           = '{frame_byte: 8'h00, frame_end: 1'b0, status: ST_OK};
    phase_next    = phase;
    in_frame_next = in_frame;
    rem_next      = rem;
    crc_next      = crc;
    done_c        = 1'b0;
    unique case (cur)
      P_BADLEN: begin
        res.status    = ST_BAD_LEN;
        in_frame_next = 1'b0;
        rem_next      = '0;
        crc_next      = CRC_INIT;
        phase_next    = P_FIRST;
        done_c        = 1'b1;
      end
      P_OUTSIDE: begin
        res.status = ST_OUTSIDE;
        phase_next = P_FIRST;
        done_c     = 1'b1;
      end
      P_MAGA: begin
        res.frame_byte = MAGIC_A;
        crc_next       = CRC_INIT;
        phase_next     = P_MAGB;
      end
      P_MAGB: begin
        res.frame_byte = MAGIC_B;
        phase_next     = P_VER;
      end
      P_VER: begin
        res.frame_byte = version;
        crc_next       = crc_feed(crc, version);
        phase_next     = P_ID;
      end
      P_ID: begin
        res.frame_byte = item.message_id;
        crc_next       = crc_feed(crc, item.message_id);
        phase_next     = P_LEN;
      end
      P_LEN: begin
        res.frame_byte = item.payload_length;
        crc_next       = crc_feed(crc, item.payload_length);
        rem_next       = REM_W'(item.payload_length);
        phase_next     = P_DATA;
      end
      P_DATA: begin
        res.frame_byte = item.data_byte;
        crc_next       = crc_feed(crc, item.data_byte);
        rem_next       = rem_dec;
        if (rem_dec == '0) begin
          phase_next = P_CRCL;
        end else begin
          in_frame_next = 1'b1;
          phase_next    = P_FIRST;
          done_c        = 1'b1;
        end
      end
      P_CRCL: begin
        res.frame_byte = crc[7:0];
        phase_next     = P_CRCH;
      end
      P_CRCH: begin
        res.frame_byte = crc[15:8];
        res.frame_end  = 1'b1;
        crc_next       = CRC_INIT;
        in_frame_next  = 1'b0;
        phase_next     = P_FIRST;
        done_c         = 1'b1;
      end
      default: begin
        phase_next = P_FIRST;
      end
    endcase
  end

  // Phase and frame state advance only when a result is produced.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= P_FIRST;
      in_frame <= 1'b0;
      rem      <= '0;
      crc      <= CRC_INIT;
    end else if (step) begin
      phase    <= phase_next;
      in_frame <= in_frame_next;
      rem      <= rem_next;
      crc      <= crc_next;
    end
  end

endmodule

`default_nettype wire

FILE: sv/crcfb_out_reg.sv
`timescale 1ns / 1ps
`default_nettype none

module crcfb_out_reg (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               load,
  input  wire crcfb_pkg::result_t res,
  output logic                    out_ready,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [7:0]              frame_byte,
  output logic                    frame_end,
  output logic [1:0]              status
);
  import crcfb_pkg::*;

  // The register can take a result when empty or when its content transfers now.
  assign out_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= load;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (out_ready && load) begin
      frame_byte <= res.frame_byte;
      frame_end  <= res.frame_end;
      status     <= res.status;
    end
  end

endmodule

`default_nettype wire

FILE: sv/crc16_frame_builder.sv
// Frame builder with CRC-16/CCITT-FALSE trailer.
// Input channel (in_valid / in_stall): one payload byte per transfer, with
// start_req, message_id and payload_length on the first byte of a message.
// Output channel (out_valid / out_stall): one frame byte per transfer, with
// frame_end on the last CRC byte and status for error results.
// Configuration channel (cfg_valid / cfg_ready): writes protocol_version;
// cfg_ready is always high. Write it only while the block is idle.
// Each input item yields 1 to 8 results from a single sequencer, one result
// per cycle while the receiver does not stall: 1 for a middle byte or an
// error, 3 for a last byte, 6 for a start, 8 for a start of length 1. The
// first result of an item passes the input register, then the output register.
// The next item is taken in the cycle the current item's last result moves
// to the output register, so payload bytes stream at one per cycle while the
// receiver does not stall.
// When the receiver stalls, the output register holds its result and the
// sequencer and input side wait. Reset empties both registers, closes any
// open frame and sets the version to 2.
`timescale 1ns / 1ps
`default_nettype none

module crc16_frame_builder #(
  parameter int MAX_PAYLOAD = 64
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [7:0] cfg_data,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic       start_req,
  input  wire logic [7:0] message_id,
  input  wire logic [7:0] payload_length,
  input  wire logic [7:0] data_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      frame_byte,
  output logic            frame_end,
  output logic [1:0]      status
);
  import crcfb_pkg::*;

  logic       [7:0] protocol_version;
  item_t            in_item, item;
  logic             item_valid, item_done;
  result_t          res;
  logic             res_valid, out_ready;

  // Version register.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      protocol_version <= VERSION_RST;
    end else if (cfg_valid && cfg_ready) begin
      protocol_version <= cfg_data;
    end
  end

  assign in_item = '{start_req: start_req, message_id: message_id,
                     payload_length: payload_length, data_byte: data_byte};

  crcfb_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .item_done  (item_done),
    .item       (item),
    .item_valid (item_valid)
  );

  crcfb_seq #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .item_valid (item_valid),
    .out_ready  (out_ready),
    .version    (protocol_version),
    .res        (res),
    .res_valid  (res_valid),
    .item_done  (item_done)
  );

  crcfb_out_reg u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .load       (res_valid),
    .res        (res),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .frame_byte (frame_byte),
    .frame_end  (frame_end),
    .status     (status)
  );

endmodule

`default_nettype wire

FILE: test/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import crcfb_pkg::*;

  localparam int MAX_LEN     = 64;
  localparam int CYCLE_LIMIT = 400000;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_data = 8'h00;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       start_req = 1'b0;
  logic [7:0] message_id = 8'h00;
  logic [7:0] payload_length = 8'h00;
  logic [7:0] data_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] frame_byte;
  logic       frame_end;
  logic [1:0] status;

  // Idle rates in percent for the byte source and the frame sink.
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  int unsigned cycle_count    = 0;
  int unsigned mismatch_count = 0;
  int unsigned bytes_accepted = 0;

  // Frame bytes the block is expected to emit, oldest first.
  result_t pending_frame_bytes[$];

  // Shadow of the framer state and the version register.
  logic [7:0]  model_version = VERSION_RST;
  logic        frame_open    = 1'b0;
  logic [7:0]  frame_left    = 8'h00;
  logic [15:0] frame_crc     = CRC_INIT;

  crc16_frame_builder #(.MAX_PAYLOAD(MAX_LEN)) dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .start_req(start_req),
    .message_id(message_id),
    .payload_length(payload_length),
    .data_byte(data_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .frame_byte(frame_byte),
    .frame_end(frame_end),
    .status(status)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Random byte value.
  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(255));
  endfunction

  // Bitwise CRC-16/CCITT-FALSE update, one data bit at a time, MSB first.
  function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ b[i];
      c  = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
    end
    return c;
  endfunction

  task automatic queue_frame_byte(input logic [7:0] b, input logic e, input logic [1:0] s);
    result_t r;
    r.frame_byte = b;
    r.frame_end  = e;
    r.status     = s;
    pending_frame_bytes.push_back(r);
  endtask

  // Pass a payload byte through and close the frame with the CRC after the last one.
  task automatic forward_payload(input logic [7:0] b);
    queue_frame_byte(b, 1'b0, ST_OK);
    frame_crc = crc_update(frame_crc, b);
    if (frame_left != 8'd0) begin
      frame_left = frame_left - 8'd1;
    end
    if (frame_left == 8'd0) begin
      queue_frame_byte(frame_crc[7:0], 1'b0, ST_OK);
      queue_frame_byte(frame_crc[15:8], 1'b1, ST_OK);
      frame_open = 1'b0;
      frame_crc  = CRC_INIT;
    end else begin
      frame_open = 1'b1;
    end
  endtask

  // Work out every frame byte caused by one accepted input byte.
  task automatic build_frame_bytes(input item_t it);
    if (it.start_req) begin
      if (it.payload_length == 8'd0 || it.payload_length > MAX_LEN) begin
        frame_open = 1'b0;
        frame_left = 8'd0;
        frame_crc  = CRC_INIT;
        queue_frame_byte(8'h00, 1'b0, ST_BAD_LEN);
      end else begin
        queue_frame_byte(MAGIC_A, 1'b0, ST_OK);
        queue_frame_byte(MAGIC_B, 1'b0, ST_OK);
        queue_frame_byte(model_version, 1'b0, ST_OK);
        queue_frame_byte(it.message_id, 1'b0, ST_OK);
        queue_frame_byte(it.payload_length, 1'b0, ST_OK);
        frame_crc  = crc_update(CRC_INIT, model_version);
        frame_crc  = crc_update(frame_crc, it.message_id);
        frame_crc  = crc_update(frame_crc, it.payload_length);
        frame_left = it.payload_length;
        forward_payload(it.data_byte);
      end
    end else if (!frame_open) begin
      queue_frame_byte(8'h00, 1'b0, ST_OUTSIDE);
    end else begin
      forward_payload(it.data_byte);
    end
  endtask

  // Offer one input byte, with random idle cycles ahead of it, until it is transferred.
  task automatic send_byte(input logic s, input logic [7:0] id, input logic [7:0] len,
                           input logic [7:0] d);
    item_t it;
    it.start_req      = s;
    it.message_id     = id;
    it.payload_length = len;
    it.data_byte      = d;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    start_req      <= s;
    message_id     <= id;
    payload_length <= len;
    data_byte      <= d;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    build_frame_bytes(it);
    bytes_accepted++;
  endtask

  // Stop offering bytes and wait until every expected frame byte has come out.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_frame_bytes.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic write_version(input logic [7:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    model_version = v;
    cfg_valid <= 1'b0;
  endtask

  // A complete frame of the given length; the trailing bytes carry random id and length.
  task automatic send_frame(input logic [7:0] len);
    send_byte(1'b1, rand_byte(), len, rand_byte());
    for (int i = 1; i < len; i++) begin
      send_byte(1'b0, rand_byte(), rand_byte(), rand_byte());
    end
  endtask

  // Mostly well-formed frames of random content, plus cut-off frames and error cases.
  task automatic random_frame();
    int unsigned kind;
    int unsigned pick;
    logic [7:0]  len;
    kind = $urandom_range(99);
    if (kind < 80) begin
      pick = $urandom_range(39);
      if (pick == 0) begin
        len = 8'(MAX_LEN);
      end else if (pick < 4) begin
        len = 8'($urandom_range(32, 7));
      end else begin
        len = 8'($urandom_range(6, 1));
      end
      send_byte(1'b1, rand_byte(), len, rand_byte());
      for (int i = 1; i < len; i++) begin
        // Now and then cut the frame short so that the next start abandons it.
        if ($urandom_range(99) < 4) begin
          break;
        end
        send_byte(1'b0, rand_byte(), rand_byte(), rand_byte());
      end
    end else if (kind < 90) begin
      len = $urandom_range(1) ? 8'd0 : 8'($urandom_range(255, MAX_LEN + 1));
      send_byte(1'b1, rand_byte(), len, rand_byte());
      repeat ($urandom_range(2)) begin
        send_byte(1'b0, rand_byte(), rand_byte(), rand_byte());
      end
    end else begin
      send_byte(1'b0, rand_byte(), rand_byte(), rand_byte());
    end
  endtask

  // The version after reset goes into the head and the CRC.
  task automatic test_default_version();
    send_byte(1'b1, 8'h12, 8'd2, 8'h34);
    send_byte(1'b0, 8'h00, 8'h00, 8'h56);
  endtask

  // Shortest frame and the extreme field values.
  task automatic test_frame_extremes();
    send_byte(1'b1, 8'h00, 8'd1, 8'h00);
    send_byte(1'b1, 8'hFF, 8'd2, 8'hFF);
    send_byte(1'b0, 8'h3C, 8'hC3, 8'h00);
  endtask

  // Zero and oversize lengths; the byte after a bad start falls outside any frame.
  task automatic test_length_errors();
    send_byte(1'b1, 8'h77, 8'd0, 8'h11);
    send_byte(1'b0, 8'h00, 8'h00, 8'h22);
    send_byte(1'b1, 8'h88, 8'(MAX_LEN + 1), 8'h33);
    send_byte(1'b1, 8'hFF, 8'hFF, 8'hFF);
  endtask

  // A byte with no frame open yields an outside status, whatever its id and length fields hold.
  task automatic test_outside_bytes();
    send_byte(1'b0, 8'hA5, 8'h5A, 8'hC9);
    send_byte(1'b0, 8'hFF, 8'hFF, 8'hFF);
  endtask

  // A start inside an open frame abandons it and opens a fresh one.
  task automatic test_restart_in_frame();
    send_byte(1'b1, 8'h05, 8'd3, 8'hAB);
    send_byte(1'b0, 8'h99, 8'h00, 8'hCD);
    send_byte(1'b1, 8'h06, 8'd1, 8'hEF);
  endtask

  // Version register at both extremes.
  task automatic test_version_register();
    wait_drained();
    write_version(8'h00);
    send_byte(1'b1, 8'h40, 8'd1, 8'h01);
    wait_drained();
    write_version(8'hFF);
    send_byte(1'b1, 8'h41, 8'd2, 8'h80);
    send_byte(1'b0, 8'h00, 8'h00, 8'h7F);
  endtask

  // Random traffic in three idle settings, with a version change between them.
  task automatic test_random_traffic();
    int unsigned goal;
    wait_drained();
    write_version(rand_byte());
    send_idle_pct = 13;
    recv_idle_pct = 76;
    goal = bytes_accepted + 40;
    while (bytes_accepted < goal) begin
      random_frame();
    end
    wait_drained();
    write_version(rand_byte());
    send_idle_pct = 76;
    recv_idle_pct = 13;
    goal = bytes_accepted + 40;
    while (bytes_accepted < goal) begin
      random_frame();
    end
    wait_drained();
    write_version(rand_byte());
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_frame(8'(MAX_LEN));
    goal = bytes_accepted + 40;
    while (bytes_accepted < goal) begin
      random_frame();
    end
    wait_drained();
  endtask

  initial begin
    send_idle_pct = 13;
    recv_idle_pct = 76;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_default_version();
    test_frame_extremes();
    test_length_errors();
    test_outside_bytes();
    test_restart_in_frame();
    test_version_register();
    test_random_traffic();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("crc16_frame_builder verification clean");
    end else begin
      $display("crc16_frame_builder verification failed");
    end
    $finish;
  end

  // The frame sink stalls at random.
  always @(posedge clk) begin
    out_stall <= (recv_idle_pct != 0) && ($urandom_range(99) < recv_idle_pct);
  end

  // Compare each transferred frame byte with the oldest expectation.
  always @(posedge clk) begin : check_frame_bytes
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_frame_bytes.size() == 0) begin
        $error("unexpected frame byte %0h (end %0b, status %0d)", frame_byte, frame_end,
               status);
        mismatch_count++;
      end else begin
        want = pending_frame_bytes.pop_front();
        if (frame_byte !== want.frame_byte) begin
          $error("frame_byte: expected %0h, got %0h", want.frame_byte, frame_byte);
          mismatch_count++;
        end
        if (frame_end !== want.frame_end) begin
          $error("frame_end: expected %0b, got %0b", want.frame_end, frame_end);
          mismatch_count++;
        end
        if (status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("crc16_frame_builder verification failed");
      $finish;
    end
  end

endmodule
